### rtl/nonzero_run_length_encoder_macros.svh
// assertion helpers for the run-length encoder
`ifndef NONZERO_RUN_LENGTH_ENCODER_MACROS_SVH
`define NONZERO_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication
`define NZRLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NZRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/nzrle_pkg.sv
package nzrle_pkg;

   localparam int COL_W  = 6;
   localparam int ROW_W  = 16;
   localparam int DATA_W = 8;
   localparam int CSR_INDEX_W = 2;

   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [DATA_W-1:0] data_type;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_COLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMIT_DATA  = 2'd2;

   localparam col_type COLS_RESET = 6'd63;
   localparam row_type ROWS_RESET = 16'd1;
   localparam logic    EMIT_RESET = 1'b1;

endpackage

### rtl/nzrle_linebuf.sv
module nzrle_linebuf #(
   parameter int DEPTH = 63,
   parameter int ADDR_W = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  nzrle_pkg::data_type    wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output nzrle_pkg::data_type    rd_data
);

   nzrle_pkg::data_type mem_ff [DEPTH];
   nzrle_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nonzero_run_length_encoder.sv
// a pixel that closes a run shows its header the cycle after acceptance
// if emit_data is set, data bytes follow from the line buffer read port one per cycle
// while rsp_ready is high; req_ready is low while a run drains: a pixel closing no run
// keeps the block idle, else it enters the header and, if emit_data is set, the data state
// reset clears counters and run state and loads config defaults; line buffer not cleared
`include "nonzero_run_length_encoder_macros.svh"

module nonzero_run_length_encoder #(
   parameter int LINE_MAX = 63
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  nzrle_pkg::data_type                    req_pixel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_kind,
   output nzrle_pkg::col_type                     rsp_run_x,
   output nzrle_pkg::row_type                     rsp_run_y,
   output nzrle_pkg::col_type                     rsp_run_length,
   output nzrle_pkg::data_type                    rsp_data_byte,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [nzrle_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nzrle_pkg::ROW_W-1:0]            csr_data
);

   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam nzrle_pkg::col_type LINE_MAX_C = nzrle_pkg::COL_W'(LINE_MAX);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_DATA
   } state_type;

   state_type           state_ff;
   nzrle_pkg::col_type  cols_ff;
   nzrle_pkg::row_type  rows_ff;
   logic                emit_ff;
   nzrle_pkg::col_type  column_ff;
   nzrle_pkg::row_type  row_ff;
   logic                in_run_ff;
   nzrle_pkg::col_type  run_start_ff;
   nzrle_pkg::col_type  run_count_ff;
   nzrle_pkg::col_type  hdr_x_ff;
   nzrle_pkg::row_type  hdr_y_ff;
   nzrle_pkg::col_type  hdr_len_ff;
   logic                hdr_emit_ff;
   nzrle_pkg::col_type  idx_ff;

   logic                req_fire;
   logic                rsp_fire;
   nzrle_pkg::col_type  cols_eff;
   logic                row_end;
   logic                px_nz;
   logic                run_open_in;
   nzrle_pkg::col_type  start_in;
   nzrle_pkg::col_type  cnt_base;
   logic                store_px;
   nzrle_pkg::col_type  cnt_in;
   logic                close_run;
   nzrle_pkg::col_type  inc_a;
   nzrle_pkg::col_type  inc_out;
   logic                data_last;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   nzrle_pkg::data_type rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // shared incrementer: column counter while idle, drain index while draining
   assign inc_a   = (state_ff == ST_IDLE) ? column_ff : idx_ff;
   assign inc_out = inc_a + nzrle_pkg::COL_W'(1);

   assign cols_eff = (cols_ff == '0 || cols_ff > LINE_MAX_C) ? LINE_MAX_C : cols_ff;
   assign row_end  = column_ff >= (cols_eff - nzrle_pkg::COL_W'(1));

   assign px_nz       = (req_pixel != '0);
   assign run_open_in = in_run_ff || px_nz;
   assign start_in    = in_run_ff ? run_start_ff : column_ff;
   assign cnt_base    = in_run_ff ? run_count_ff : '0;
   assign store_px    = px_nz && (cnt_base < LINE_MAX_C);
   assign cnt_in      = store_px ? (cnt_base + nzrle_pkg::COL_W'(1)) : cnt_base;
   assign close_run   = run_open_in && (!px_nz || row_end);

   assign data_last = (idx_ff == (hdr_len_ff - nzrle_pkg::COL_W'(1)));

   // read is launched as the previous result leaves so data is ready next cycle
   assign rd_en   = rsp_fire && (((state_ff == ST_HDR) && hdr_emit_ff) ||
                                 ((state_ff == ST_DATA) && !data_last));
   assign rd_addr = (state_ff == ST_HDR) ? '0 : inc_out[ADDR_W-1:0];

   nzrle_linebuf #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (ADDR_W)
   ) u_linebuf (
      .clock   (clock),
      .wr_en   (req_fire && store_px),
      .wr_addr (cnt_base[ADDR_W-1:0]),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_ff      <= nzrle_pkg::COLS_RESET;
         rows_ff      <= nzrle_pkg::ROWS_RESET;
         emit_ff      <= nzrle_pkg::EMIT_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         run_count_ff <= '0;
         hdr_x_ff     <= '0;
         hdr_y_ff     <= '0;
         hdr_len_ff   <= '0;
         hdr_emit_ff  <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               nzrle_pkg::CSR_IMAGE_COLS: cols_ff <= csr_data[nzrle_pkg::COL_W-1:0];
               nzrle_pkg::CSR_IMAGE_ROWS: rows_ff <= csr_data;
               nzrle_pkg::CSR_EMIT_DATA:  emit_ff <= csr_data[0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (close_run) begin
                     in_run_ff    <= 1'b0;
                     run_start_ff <= '0;
                     run_count_ff <= '0;
                     hdr_x_ff     <= start_in;
                     hdr_y_ff     <= row_ff;
                     hdr_len_ff   <= cnt_in;
                     hdr_emit_ff  <= emit_ff;
                     state_ff     <= ST_HDR;
                  end else begin
                     in_run_ff    <= run_open_in;
                     run_start_ff <= run_open_in ? start_in : '0;
                     run_count_ff <= run_open_in ? cnt_in : '0;
                  end
                  if (row_end) begin
                     column_ff <= '0;
                     if (row_ff == (rows_ff - nzrle_pkg::ROW_W'(1))) begin
                        row_ff <= '0;
                     end else begin
                        row_ff <= row_ff + nzrle_pkg::ROW_W'(1);
                     end
                  end else begin
                     column_ff <= inc_out;
                  end
               end
            end
            ST_HDR: begin
               if (rsp_fire) begin
                  idx_ff   <= '0;
                  state_ff <= hdr_emit_ff ? ST_DATA : ST_IDLE;
               end
            end
            ST_DATA: begin
               if (rsp_fire) begin
                  if (data_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= inc_out;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = (state_ff == ST_HDR) || (state_ff == ST_DATA);
   assign rsp_kind       = (state_ff == ST_DATA) ? nzrle_pkg::KIND_DATA
                                                 : nzrle_pkg::KIND_HEADER;
   assign rsp_run_x      = (state_ff == ST_HDR) ? hdr_x_ff : '0;
   assign rsp_run_y      = (state_ff == ST_HDR) ? hdr_y_ff : '0;
   assign rsp_run_length = (state_ff == ST_HDR) ? hdr_len_ff : '0;
   assign rsp_data_byte  = (state_ff == ST_DATA) ? rd_data : '0;
   assign rsp_last       = (state_ff == ST_HDR) ? !hdr_emit_ff
                                                : ((state_ff == ST_DATA) && data_last);

   `NZRLE_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready,
                     "accepting during drain")
   `NZRLE_ASSERT_NEXT(a_last_frees, clock, reset, rsp_fire && rsp_last, req_ready,
                      "not idle after last")
   `NZRLE_ASSERT_NOW(a_idx_in_run, clock, reset, state_ff == ST_DATA,
                     idx_ff < hdr_len_ff, "drain index past run")
   `NZRLE_ASSERT_NOW(a_hdr_len, clock, reset, state_ff == ST_HDR,
                     (hdr_len_ff != '0) && (hdr_len_ff <= LINE_MAX_C), "bad run length")
   `NZRLE_ASSERT_NEXT(a_close_hdr, clock, reset, req_fire && close_run,
                      state_ff == ST_HDR, "closed run without header")

endmodule

### sim/nonzero_run_length_encoder_tb.sv
module nonzero_run_length_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX     = 63;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 410;
   localparam int PRESSURE_AT  = 100;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic                kind;
      nzrle_pkg::col_type  run_x;
      nzrle_pkg::row_type  run_y;
      nzrle_pkg::col_type  run_length;
      nzrle_pkg::data_type data_byte;
      logic                last;
   } run_record_type;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;

   typedef struct {
      step_kind_type                     op;
      logic [nzrle_pkg::CSR_INDEX_W-1:0] index;
      nzrle_pkg::row_type                value;
      logic                              typed;
      nzrle_pkg::col_type                hx;
      nzrle_pkg::row_type                hy;
      nzrle_pkg::col_type                hlen;
   } script_step_type;

   localparam int SCRIPT_LEN = 33;

   script_step_type script [SCRIPT_LEN] = '{
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_COLS, 16'd4,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_ROWS, 16'd2,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_EMIT_DATA,  16'd1,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd255,   1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b1, 6'd0, 16'd0, 6'd1},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd1,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd128,   1'b1, 6'd2, 16'd0, 6'd2},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd7,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd7,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd7,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd7,     1'b1, 6'd0, 16'd0, 6'd4},
      '{STEP_WRITE, nzrle_pkg::CSR_EMIT_DATA,  16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd9,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b1, 6'd1, 16'd1, 6'd1},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_ROWS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_COLS, 16'd1,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd255,   1'b1, 6'd0, 16'd0, 6'd1},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd1,     1'b1, 6'd0, 16'd2, 6'd1},
      '{STEP_WRITE, nzrle_pkg::CSR_EMIT_DATA,  16'd1,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_COLS, 16'd4,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd200,   1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd201,   1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_COLS, 16'd2,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_PIXEL, nzrle_pkg::CSR_IMAGE_COLS, 16'd202,   1'b1, 6'd0, 16'd3, 6'd3},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_COLS, 16'd0,     1'b0, 6'd0, 16'd0, 6'd0},
      '{STEP_WRITE, nzrle_pkg::CSR_IMAGE_ROWS, 16'd65535, 1'b0, 6'd0, 16'd0, 6'd0}
   };

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   nzrle_pkg::data_type               req_pixel;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_kind;
   nzrle_pkg::col_type                rsp_run_x;
   nzrle_pkg::row_type                rsp_run_y;
   nzrle_pkg::col_type                rsp_run_length;
   nzrle_pkg::data_type               rsp_data_byte;
   logic                              rsp_last;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [nzrle_pkg::CSR_INDEX_W-1:0] csr_index;
   nzrle_pkg::row_type                csr_data;

   // shadow of the encoder
   nzrle_pkg::col_type  cfg_cols;
   nzrle_pkg::row_type  cfg_rows;
   logic                cfg_emit;
   nzrle_pkg::col_type  col_count;
   nzrle_pkg::row_type  row_count;
   logic                run_open;
   nzrle_pkg::col_type  run_start;
   nzrle_pkg::col_type  run_count;
   nzrle_pkg::data_type line_buf [LINE_MAX];

   run_record_type records_due [$];

   int sender_gap_max  = 10;
   int reply_stall_max = 10;
   int mismatches      = 0;
   int records_checked = 0;
   int headers_seen    = 0;
   int bytes_seen      = 0;
   int csr_writes      = 0;
   int random_pixels   = 0;
   logic held_off      = 1'b0;

   always #10 clock = ~clock;

   nonzero_run_length_encoder #(.LINE_MAX(LINE_MAX)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_run_x      (rsp_run_x),
      .rsp_run_y      (rsp_run_y),
      .rsp_run_length (rsp_run_length),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   function automatic int close_run();
      run_record_type rec;
      int produced;
      produced = 0;
      if (!run_open) return 0;
      rec = '{nzrle_pkg::KIND_HEADER, run_start, row_count, run_count, '0, !cfg_emit};
      records_due.push_back(rec);
      produced++;
      if (cfg_emit) begin
         for (int i = 0; i < int'(run_count); i++) begin
            rec = '{nzrle_pkg::KIND_DATA, '0, '0, '0, line_buf[i],
                    i == int'(run_count) - 1};
            records_due.push_back(rec);
            produced++;
         end
      end
      run_open  = 1'b0;
      run_count = '0;
      run_start = '0;
      return produced;
   endfunction

   function automatic int encode_pixel(nzrle_pkg::data_type px);
      int   produced;
      int   span;
      logic row_end;
      produced = 0;
      span = (cfg_cols == '0) ? LINE_MAX : int'(cfg_cols);
      row_end = int'(col_count) >= span - 1;
      if (px != '0) begin
         if (!run_open) begin
            run_open  = 1'b1;
            run_start = col_count;
            run_count = '0;
         end
         if (int'(run_count) < LINE_MAX) begin
            line_buf[run_count] = px;
            run_count = run_count + 1'b1;
         end
      end else begin
         produced = close_run();
      end
      if (row_end) begin
         produced += close_run();
         col_count = '0;
         if (row_count == nzrle_pkg::row_type'(cfg_rows - 16'd1))
            row_count = '0;
         else
            row_count = row_count + 16'd1;
      end else begin
         col_count = col_count + 1'b1;
      end
      return produced;
   endfunction

   task automatic send_pixel(input nzrle_pkg::data_type px, output int produced);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!(req_valid && req_ready));
      produced = encode_pixel(px);
   endtask

   task automatic write_reg(input logic [nzrle_pkg::CSR_INDEX_W-1:0] idx,
                            input nzrle_pkg::row_type val);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         nzrle_pkg::CSR_IMAGE_COLS: cfg_cols = val[nzrle_pkg::COL_W-1:0];
         nzrle_pkg::CSR_IMAGE_ROWS: cfg_rows = val;
         nzrle_pkg::CSR_EMIT_DATA:  cfg_emit = val[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // result side
   initial begin
      int stall;
      run_record_type want;
      wait (reset === 1'b0);
      forever begin
         if (!held_off && records_checked == PRESSURE_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         stall = $urandom_range(0, reply_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         records_checked++;
         if (records_due.size() == 0) begin
            $error("unexpected transaction: kind %0d x %0d y %0d len %0d byte %0d",
                   rsp_kind, rsp_run_x, rsp_run_y, rsp_run_length, rsp_data_byte);
            mismatches++;
         end else begin
            want = records_due.pop_front();
            check_field("kind",       want.kind,       rsp_kind);
            check_field("run_x",      want.run_x,      rsp_run_x);
            check_field("run_y",      want.run_y,      rsp_run_y);
            check_field("run_length", want.run_length, rsp_run_length);
            check_field("data_byte",  want.data_byte,  rsp_data_byte);
            check_field("last",       want.last,       rsp_last);
            if (want.kind == nzrle_pkg::KIND_HEADER) headers_seen++;
            else bytes_seen++;
         end
      end
   end

   initial begin
      #80_000_000;
      $display("nonzero_run_length_encoder regression: fail");
      $finish;
   end

   initial begin
      int                  produced;
      int                  n;
      int                  zero_pct;
      int                  phase;
      int                  slot;
      nzrle_pkg::data_type px;
      nzrle_pkg::row_type  cols_val;
      nzrle_pkg::row_type  rows_val;
      logic                last_was_write;
      run_record_type      hdr;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = nzrle_pkg::CSR_IMAGE_COLS;
      csr_data  = '0;
      cfg_cols  = nzrle_pkg::COLS_RESET;
      cfg_rows  = nzrle_pkg::ROWS_RESET;
      cfg_emit  = nzrle_pkg::EMIT_RESET;
      col_count = '0;
      row_count = '0;
      run_open  = 1'b0;
      run_start = '0;
      run_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      last_was_write = 1'b1;
      foreach (script[i]) begin
         if (script[i].op == STEP_WRITE) begin
            if (!last_was_write) wait_idle();
            write_reg(script[i].index, script[i].value);
            last_was_write = 1'b1;
         end else begin
            send_pixel(script[i].value[nzrle_pkg::DATA_W-1:0], produced);
            last_was_write = 1'b0;
            if (script[i].typed) begin
               if (produced == 0) begin
                  hdr = '{nzrle_pkg::KIND_HEADER, script[i].hx, script[i].hy,
                          script[i].hlen, '0, 1'b1};
                  records_due.push_back(hdr);
               end else begin
                  slot = records_due.size() - produced;
                  hdr = records_due[slot];
                  hdr.run_x      = script[i].hx;
                  hdr.run_y      = script[i].hy;
                  hdr.run_length = script[i].hlen;
                  records_due[slot] = hdr;
               end
            end
         end
      end

      phase = 0;
      while (random_pixels < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 4))
            0:       cols_val = 16'd0;
            1:       cols_val = 16'd1;
            2:       cols_val = 16'd63;
            3:       cols_val = nzrle_pkg::row_type'($urandom_range(0, 65535));
            default: cols_val = nzrle_pkg::row_type'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 4))
            0:       rows_val = 16'd0;
            1:       rows_val = 16'd1;
            2:       rows_val = 16'd65535;
            default: rows_val = nzrle_pkg::row_type'($urandom_range(2, 6));
         endcase
         if (phase == 0) cols_val = 16'd63;
         write_reg(nzrle_pkg::CSR_IMAGE_COLS, cols_val);
         write_reg(nzrle_pkg::CSR_IMAGE_ROWS, rows_val);
         write_reg(nzrle_pkg::CSR_EMIT_DATA, nzrle_pkg::row_type'($urandom_range(0, 65535)));
         case ($urandom_range(0, 3))
            0:       zero_pct = 0;
            1:       zero_pct = 15;
            2:       zero_pct = 50;
            default: zero_pct = 85;
         endcase
         case ($urandom_range(0, 2))
            0:       sender_gap_max = 0;
            1:       sender_gap_max = 3;
            default: sender_gap_max = 10;
         endcase
         case ($urandom_range(0, 2))
            0:       reply_stall_max = 0;
            1:       reply_stall_max = 3;
            default: reply_stall_max = 10;
         endcase
         n = $urandom_range(30, 56);
         if (phase == 0) begin
            zero_pct = 0;
            n = 70;
         end
         if (n > RANDOM_ITEMS - random_pixels) n = RANDOM_ITEMS - random_pixels;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < zero_pct) px = '0;
            else px = nzrle_pkg::data_type'($urandom_range(1, 255));
            send_pixel(px, produced);
            random_pixels++;
         end
         phase++;
      end

      wait_idle();
      $display("drove the directed table and %0d random pixels over %0d register settings",
               random_pixels, phase);
      $display("checked %0d run headers and %0d run bytes after %0d register writes",
               headers_seen, bytes_seen, csr_writes);
      if (mismatches == 0)
         $display("nonzero_run_length_encoder regression: pass");
      else
         $display("nonzero_run_length_encoder regression: fail");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/nzrle_pkg.sv
rtl/nzrle_linebuf.sv
rtl/nonzero_run_length_encoder.sv
sim/nonzero_run_length_encoder_tb.sv
